// ===== rtl/core/assert_macros.svh =====
// assert_macros.svh: assertion macros shared by the verlet integrator rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masked
`define SVI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svi assertion failed");

// next-cycle implication, reset masked
`define SVI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svi assertion failed");

`endif

// ===== rtl/core/svi_pkg.sv =====
// svi_pkg: types, constants and helpers of the sub-stepped verlet integrator
// no dependencies
`default_nettype none
package svi_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned DT_W       = 16;
  localparam int unsigned DIVIDEND_W = 32;
  localparam int unsigned DIV_CNT_W  = 5;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned SUM_W      = 34;
  localparam logic [DT_W-1:0] MAX_FT_RESET = 16'd6554;

  typedef enum logic [2:0] {
    OP_IDLE = 3'd0,
    OP_LOAD = 3'd1,
    OP_HMUL = 3'd2,
    OP_HSET = 3'd3,
    OP_VMUL = 3'd4,
    OP_UPD  = 3'd5
  } lane_op_t;

  typedef struct packed {
    lane_op_t op;
    logic     last;
  } lane_ctrl_t;

  typedef struct packed {
    logic              hit;
    logic [WORD_W-1:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [SUM_W-1:0] v);
    sat_t s;
    if (v > $signed(SUM_W'(34'sh0_7FFF_FFFF))) begin
      s.hit = 1'b1;
      s.val = 32'h7FFF_FFFF;
    end else if (v < -$signed(SUM_W'(34'sh0_8000_0000))) begin
      s.hit = 1'b1;
      s.val = 32'h8000_0000;
    end else begin
      s.hit = 1'b0;
      s.val = v[WORD_W-1:0];
    end
    return s;
  endfunction

  function automatic logic [WORD_W-1:0] mag32(input logic [WORD_W-1:0] x);
    return x[WORD_W-1] ? (~x + 32'd1) : x;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/svi_div.sv =====
// svi_div: restoring divider, one quotient bit per cycle, for the sub-step length
// uses svi_pkg
`default_nettype none
module svi_div #(
  parameter int unsigned DIVISOR_W = 7
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [svi_pkg::DIVIDEND_W-1:0]    dividend,
  input  wire logic [DIVISOR_W-1:0]              divisor,
  output logic                                   done,
  output logic [svi_pkg::DIVIDEND_W-1:0]         quot
);

  logic                               busy_r;
  logic [svi_pkg::DIV_CNT_W-1:0]      cnt_r;
  logic [svi_pkg::DIVIDEND_W-1:0]     quot_r, quot_nxt;
  logic [DIVISOR_W:0]                 rem_r, rem_nxt, rem_sh;
  logic [DIVISOR_W-1:0]               dvs_r;
  logic                               done_r;

  always_comb begin
    rem_sh = {rem_r[DIVISOR_W-1:0], quot_r[svi_pkg::DIVIDEND_W-1]};
    quot_nxt = {quot_r[svi_pkg::DIVIDEND_W-2:0], 1'b0};
    rem_nxt = rem_sh;
    if (rem_sh >= {1'b0, dvs_r}) begin
      rem_nxt = rem_sh - {1'b0, dvs_r};
      quot_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (&cnt_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
`default_nettype wire

// ===== rtl/core/svi_lane.sv =====
// svi_lane: one axis of the integrator, holds p, v, a and runs sub-step phases
// uses svi_pkg
`default_nettype none
module svi_lane (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire svi_pkg::lane_ctrl_t           ctrl,
  input  wire logic [svi_pkg::WORD_W-1:0]    ld_pos,
  input  wire logic [svi_pkg::WORD_W-1:0]    ld_vel,
  input  wire logic [svi_pkg::WORD_W-1:0]    ld_acc,
  input  wire logic [svi_pkg::WORD_W-1:0]    step_h,
  output logic [svi_pkg::WORD_W-1:0]         pos,
  output logic [svi_pkg::WORD_W-1:0]         vel,
  output logic                               lim
);

  logic [svi_pkg::WORD_W-1:0]          p_r, v_r, v1_r, a_r;
  logic signed [svi_pkg::SUM_W-1:0]    ha_r;
  logic [svi_pkg::PROD_W-1:0]          prod_r;
  logic                                neg_r;
  logic                                lim_r;

  logic [svi_pkg::PROD_W-1:0]          r33_full, r32_full;
  logic signed [svi_pkg::SUM_W-1:0]    r33_s, r32_s;
  svi_pkg::sat_t                       s_v1, s_p, s_vn, s_v1n;

  always_comb begin
    r33_full = (prod_r + 64'h0000_0001_0000_0000) >> 33;
    r32_full = (prod_r + 64'h0000_0000_8000_0000) >> 32;
    r33_s = neg_r ? -$signed(r33_full[svi_pkg::SUM_W-1:0])
                  :  $signed(r33_full[svi_pkg::SUM_W-1:0]);
    r32_s = neg_r ? -$signed(r32_full[svi_pkg::SUM_W-1:0])
                  :  $signed(r32_full[svi_pkg::SUM_W-1:0]);
    // velocity half kick at load of ha
    s_v1  = svi_pkg::sat32($signed({{2{v_r[31]}}, v_r}) + r33_s);
    s_p   = svi_pkg::sat32($signed({{2{p_r[31]}}, p_r}) + r32_s);
    s_vn  = svi_pkg::sat32($signed({{2{v1_r[31]}}, v1_r}) + ha_r);
    s_v1n = svi_pkg::sat32($signed({{2{s_vn.val[31]}}, s_vn.val}) + ha_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= 1'b0;
    end else begin
      case (ctrl.op)
        svi_pkg::OP_LOAD: lim_r <= 1'b0;
        svi_pkg::OP_HSET: lim_r <= lim_r | s_v1.hit;
        svi_pkg::OP_UPD:  lim_r <= lim_r | s_p.hit | s_vn.hit | (~ctrl.last & s_v1n.hit);
        default:          lim_r <= lim_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      svi_pkg::OP_LOAD: begin
        p_r <= ld_pos;
        v_r <= ld_vel;
        a_r <= ld_acc;
      end
      svi_pkg::OP_HMUL: begin
        prod_r <= svi_pkg::PROD_W'(svi_pkg::mag32(a_r)) * svi_pkg::PROD_W'(step_h);
        neg_r  <= a_r[31];
      end
      svi_pkg::OP_HSET: begin
        ha_r <= r33_s;
        v1_r <= s_v1.val;
      end
      svi_pkg::OP_VMUL: begin
        prod_r <= svi_pkg::PROD_W'(svi_pkg::mag32(v1_r)) * svi_pkg::PROD_W'(step_h);
        neg_r  <= v1_r[31];
      end
      svi_pkg::OP_UPD: begin
        p_r <= s_p.val;
        v_r <= s_vn.val;
        if (!ctrl.last) begin
          v1_r <= s_v1n.val;
        end
      end
      default: begin
      end
    endcase
  end

  assign pos = p_r;
  assign vel = v_r;
  assign lim = lim_r;

endmodule
`default_nettype wire

// ===== rtl/core/substep_verlet_integrator_unit.sv =====
// substep_verlet_integrator_unit: top level, sequencer, three axis lanes and merge
// uses svi_pkg, svi_div, svi_lane, assert_macros.svh
//
// channel  dir  handshake                  payload
// in_      in   in_tvalid/in_tready        in_tdata (304b), in_tuser (1b)
// out_     out  out_tvalid/out_tready      out_tdata (200b), out_tuser (2b)
// cfg_     in   cfg_valid/cfg_ready        cfg_data (16b) max_frame_time
//
// one word at a time: the accept, ST_CNT and ST_NSET for the count, the
// sub-step divide, ST_HMUL and ST_HSET to set up the half kick, ST_VMUL and
// ST_UPD per sub-step (shared multiplier per lane) and ST_DONE to hand off;
// a passed-through word goes to ST_DONE; a stalled result holds the hand-off
// the output register lets the next word enter while a result waits
// synchronous active-low reset; max_frame_time resets to 6554
`default_nettype none
`include "assert_macros.svh"
module substep_verlet_integrator_unit #(
  parameter int unsigned MAX_SUBSTEPS = 64,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z, frame_dt
  input  wire logic [303:0]  in_tdata,
  // active
  input  wire logic [0:0]    in_tuser,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
  // substeps_used, one pad bit
  output logic [199:0]       out_tdata,
  // frame_skipped, limit_hit
  output logic [1:0]         out_tuser,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [15:0]   cfg_data
);

  localparam int unsigned CNT_W   = $clog2(MAX_SUBSTEPS + 1);
  localparam int unsigned Q_W     = svi_pkg::WORD_W + svi_pkg::DT_W;
  localparam int unsigned SHIFT   = FRAC_BITS + 16;
  localparam int unsigned NRAW_W  = Q_W - SHIFT;
  localparam int unsigned LANES   = 3;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_CNT  = 9'b000000010,
    ST_NSET = 9'b000000100,
    ST_DIV  = 9'b000001000,
    ST_HMUL = 9'b000010000,
    ST_HSET = 9'b000100000,
    ST_VMUL = 9'b001000000,
    ST_UPD  = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [svi_pkg::DT_W-1:0]      max_ft_r;
  logic [svi_pkg::DT_W-1:0]      dt_r;
  logic [svi_pkg::WORD_W-1:0]    m_r;
  logic [Q_W-1:0]                q_r;
  logic [CNT_W-1:0]              n_r, step_r;
  logic [svi_pkg::WORD_W-1:0]    h_r;
  logic                          skip_r, cnt_lim_r;
  logic                          out_valid_r;
  logic [199:0]                  out_data_r;
  logic [1:0]                    out_user_r;

  logic                          in_acc;
  logic                          out_free;
  logic [svi_pkg::WORD_W-1:0]    mag_vx, mag_vy;
  logic [svi_pkg::DT_W-1:0]      in_dt;
  logic                          in_skip, in_run;
  logic [NRAW_W:0]               n_ceil;
  logic [CNT_W-1:0]              n_sel;
  logic                          n_sat;
  logic                          div_start, div_done;
  logic [svi_pkg::DIVIDEND_W-1:0] div_quot;
  svi_pkg::lane_ctrl_t           lane_ctrl;
  logic [svi_pkg::WORD_W-1:0]    lane_pos [LANES];
  logic [svi_pkg::WORD_W-1:0]    lane_vel [LANES];
  logic [LANES-1:0]              lane_lim;
  logic                          last_step;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;

  assign in_dt   = in_tdata[303:288];
  assign mag_vx  = svi_pkg::mag32(in_tdata[127:96]);
  assign mag_vy  = svi_pkg::mag32(in_tdata[159:128]);
  assign in_skip = in_dt > max_ft_r;
  assign in_run  = ~in_skip & in_tuser[0];

  // sub-step count: ceiling of the speed-time product, clamped
  always_comb begin
    n_ceil = {1'b0, q_r[Q_W-1:SHIFT]} + (NRAW_W+1)'(|q_r[SHIFT-1:0]);
    n_sat  = 1'b0;
    if (n_ceil == '0) begin
      n_sel = CNT_W'(1);
    end else if (Q_W'(n_ceil) > Q_W'(MAX_SUBSTEPS)) begin
      n_sel = CNT_W'(MAX_SUBSTEPS);
      n_sat = 1'b1;
    end else begin
      n_sel = CNT_W'(n_ceil);
    end
  end

  assign last_step = (step_r == n_r);
  assign div_start = (state_r == ST_NSET);

  always_comb begin
    state_nxt = state_r;
    lane_ctrl.op   = svi_pkg::OP_IDLE;
    lane_ctrl.last = last_step;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          lane_ctrl.op = svi_pkg::OP_LOAD;
          state_nxt = in_run ? ST_CNT : ST_DONE;
        end
      end
      ST_CNT:  state_nxt = ST_NSET;
      ST_NSET: state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_HMUL;
      ST_HMUL: begin
        lane_ctrl.op = svi_pkg::OP_HMUL;
        state_nxt = ST_HSET;
      end
      ST_HSET: begin
        lane_ctrl.op = svi_pkg::OP_HSET;
        state_nxt = ST_VMUL;
      end
      ST_VMUL: begin
        lane_ctrl.op = svi_pkg::OP_VMUL;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        lane_ctrl.op = svi_pkg::OP_UPD;
        state_nxt = last_step ? ST_DONE : ST_VMUL;
      end
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      max_ft_r    <= svi_pkg::MAX_FT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        max_ft_r <= cfg_data;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dt_r      <= in_dt;
      m_r       <= (mag_vx > mag_vy) ? mag_vx : mag_vy;
      skip_r    <= in_skip;
      n_r       <= '0;
      cnt_lim_r <= 1'b0;
    end
    if (state_r == ST_CNT) begin
      q_r <= Q_W'(m_r) * Q_W'(dt_r);
    end
    if (state_r == ST_NSET) begin
      n_r       <= n_sel;
      cnt_lim_r <= n_sat;
    end
    if (state_r == ST_DIV && div_done) begin
      h_r    <= div_quot;
      step_r <= CNT_W'(1);
    end
    if (state_r == ST_UPD) begin
      step_r <= step_r + 1'b1;
    end
    // merge the lanes into the output word
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= {1'b0, 7'(n_r), lane_vel[2], lane_vel[1], lane_vel[0],
                     lane_pos[2], lane_pos[1], lane_pos[0]};
      out_user_r <= {cnt_lim_r | (|lane_lim), skip_r};
    end
  end

  // divisor taken straight from the clamp, n_r is written on the same edge
  svi_div #(
    .DIVISOR_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({dt_r, 16'h0000}),
    .divisor  (n_sel),
    .done     (div_done),
    .quot     (div_quot)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    svi_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (lane_ctrl),
      .ld_pos (in_tdata[i*32 +: 32]),
      .ld_vel (in_tdata[(i+3)*32 +: 32]),
      .ld_acc (in_tdata[(i+6)*32 +: 32]),
      .step_h (h_r),
      .pos    (lane_pos[i]),
      .vel    (lane_vel[i]),
      .lim    (lane_lim[i])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `SVI_ASSERT_NEXT(a_run_to_cnt, clk, rst_n, in_acc && in_run, state_r == ST_CNT)
  `SVI_ASSERT_IMPL(a_div_in_wait, clk, rst_n, div_done, state_r == ST_DIV)
  `SVI_ASSERT_IMPL(a_skip_no_steps, clk, rst_n, out_valid_r && out_user_r[0],
                   out_data_r[198:192] == 7'd0 && !out_user_r[1])

endmodule
`default_nettype wire
